// ----- src/sctag_pkg.sv -----
// Shared constants and types for the sector cache tag engine.
// No dependencies; every other file refers to it by scoped names.
package sctag_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = $clog2(ENTRIES);

   localparam int CMD_W  = 3;
   localparam int TAG_W  = 32;
   localparam int AGE_W  = 32;
   localparam int SLOT_W = 4;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CMD_W-1:0] cmd_type;
   typedef logic [TAG_W-1:0] tag_type;
   typedef logic [AGE_W-1:0] age_type;
   typedef logic [SLOT_W-1:0] slot_type;

   localparam idx_type LAST_IDX = idx_type'(ENTRIES - 1);

   localparam cmd_type CMD_LOOKUP     = 3'd0;
   localparam cmd_type CMD_STORE      = 3'd1;
   localparam cmd_type CMD_FREE       = 3'd2;
   localparam cmd_type CMD_INVALIDATE = 3'd3;
   localparam cmd_type CMD_FLUSH      = 3'd4;

endpackage

// ----- src/sctag_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
// Depends on sctag_pkg for field widths.
interface sctag_req_if;
   logic                 valid;
   logic                 ready;
   sctag_pkg::cmd_type   cmd;
   sctag_pkg::tag_type   sector;
   logic                 mark_dirty;
   sctag_pkg::age_type   timestamp;

   modport source (output valid, cmd, sector, mark_dirty, timestamp, input ready);
   modport sink   (input valid, cmd, sector, mark_dirty, timestamp, output ready);
endinterface

interface sctag_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 success;
   sctag_pkg::slot_type  slot;
   sctag_pkg::tag_type   flush_sector;
   logic                 any_dirty;
   logic                 last;

   modport source (output valid, success, slot, flush_sector, any_dirty, last, input ready);
   modport sink   (input valid, success, slot, flush_sector, any_dirty, last, output ready);
endinterface

// ----- src/sector_cache_tag_engine_core.sv -----
// Sector cache tag engine: tag, age and valid/dirty bookkeeping of a fully
// associative write-back cache. Depends on sctag_pkg and sctag_if.
//
// One command is taken at a time. Lookup, store and free make one pass over
// all ENTRIES slots through the single read port of the tag/age memories,
// one slot per cycle, with one shared equality compare and one shared
// less-than compare; the result is registered in the apply state once the
// output register is free, and the next request is taken after that. Invalidate
// all and unused codes skip the pass and register their response in the apply
// state. Flush repeats the pass once per dirty entry, giving one response per
// pass (ascending sector order), and a single response with success 0 when
// nothing is dirty.
// The response sits in an output register, so a new request can be taken
// while the previous response waits for its transfer. The slot number on a
// response addresses the external data memory. No clearing pass is needed
// after reset: valid bits reset, and a tag/age entry only decides a result once
// written.
module sector_cache_tag_engine_core (
   input  logic               clock,
   input  logic               reset,
   sctag_req_if.sink          req_if,
   sctag_rsp_if.source        rsp_if
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_APPLY = 2'd2;

   // tag and age storage, one write and one registered read per cycle
   sctag_pkg::tag_type tag_mem [sctag_pkg::ENTRIES];
   sctag_pkg::age_type age_mem [sctag_pkg::ENTRIES];

   logic [1:0]                    state_ff, state_in;
   sctag_pkg::cmd_type            cmd_ff, cmd_in;
   sctag_pkg::tag_type            sector_ff, sector_in;
   logic                          mdirty_ff, mdirty_in;
   sctag_pkg::age_type            ts_ff, ts_in;

   // scan pipeline: issue address, then registered memory data
   sctag_pkg::idx_type            rd_idx_ff, rd_idx_in;
   logic                          issue_on_ff, issue_on_in;
   logic                          dat_vld_ff, dat_vld_in;
   sctag_pkg::idx_type            dat_idx_ff, dat_idx_in;
   sctag_pkg::tag_type            tag_rd_ff;
   sctag_pkg::age_type            age_rd_ff;

   // scan findings
   logic                          hit_found_ff, hit_found_in;
   sctag_pkg::idx_type            hit_idx_ff, hit_idx_in;
   logic                          free_found_ff, free_found_in;
   sctag_pkg::idx_type            free_idx_ff, free_idx_in;
   logic                          cand_found_ff, cand_found_in;
   sctag_pkg::idx_type            cand_idx_ff, cand_idx_in;
   sctag_pkg::tag_type            best_ff, best_in;

   logic [sctag_pkg::ENTRIES-1:0] valid_ff, valid_in;
   logic [sctag_pkg::ENTRIES-1:0] dirty_ff, dirty_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          success_ff, success_in;
   sctag_pkg::slot_type           slot_ff, slot_in;
   sctag_pkg::tag_type            flush_sector_ff, flush_sector_in;
   logic                          any_dirty_ff, any_dirty_in;
   logic                          last_ff, last_in;

   logic                          req_fire;
   logic                          out_free;
   logic                          apply_fire;
   logic                          scan_step;
   logic                          scan_start;
   logic                          tag_eq;
   logic                          lt;
   sctag_pkg::tag_type            cmp_a;
   logic                          ent_valid;
   logic                          ent_dirty;
   sctag_pkg::idx_type            pick_idx;
   logic                          pick_ok;
   logic                          tag_we;
   logic                          age_we;
   sctag_pkg::age_type            age_wdata;
   logic                          flush_last;

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign req_fire            = req_if.valid && req_if.ready;
   assign out_free            = !rsp_valid_ff || rsp_if.ready;
   assign apply_fire          = (state_ff == ST_APPLY) && out_free;
   assign scan_step           = (state_ff == ST_SCAN) && dat_vld_ff;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.success      = success_ff;
   assign rsp_if.slot         = slot_ff;
   assign rsp_if.flush_sector = flush_sector_ff;
   assign rsp_if.any_dirty    = any_dirty_ff;
   assign rsp_if.last         = last_ff;

   // shared compare unit: tag match, and less-than on age (store) or tag (flush)
   assign ent_valid = valid_ff[dat_idx_ff];
   assign ent_dirty = dirty_ff[dat_idx_ff];
   assign tag_eq    = (tag_rd_ff == sector_ff);
   assign cmp_a     = (cmd_ff == sctag_pkg::CMD_FLUSH) ? tag_rd_ff
                                                      : sctag_pkg::TAG_W'(age_rd_ff);
   assign lt        = (cmp_a < best_ff);

   // slot chosen at the end of a pass; a lookup hit steers the age write
   always_comb begin
      pick_idx = cand_idx_ff;
      pick_ok  = cand_found_ff;
      if (cmd_ff == sctag_pkg::CMD_LOOKUP) begin
         pick_idx = hit_idx_ff;
         pick_ok  = hit_found_ff;
      end else if (cmd_ff == sctag_pkg::CMD_STORE) begin
         if (hit_found_ff) begin
            pick_idx = hit_idx_ff;
            pick_ok  = 1'b1;
         end else if (free_found_ff) begin
            pick_idx = free_idx_ff;
            pick_ok  = 1'b1;
         end
      end
   end

   // memory write port
   always_comb begin
      tag_we    = 1'b0;
      age_we    = 1'b0;
      age_wdata = ts_ff;
      if (apply_fire) begin
         case (cmd_ff)
            sctag_pkg::CMD_LOOKUP: begin
               age_we = hit_found_ff;
            end
            sctag_pkg::CMD_STORE: begin
               tag_we    = pick_ok;
               age_we    = pick_ok;
               age_wdata = '0;
            end
            default: begin
               tag_we = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[pick_idx] <= sector_ff;
      end
      if (age_we) begin
         age_mem[pick_idx] <= age_wdata;
      end
      tag_rd_ff <= tag_mem[rd_idx_ff];
      age_rd_ff <= age_mem[rd_idx_ff];
   end

   // valid and dirty bits
   always_comb begin
      valid_in = valid_ff;
      dirty_in = dirty_ff;
      // free drops every matching valid entry as the pass goes by
      if (scan_step && (cmd_ff == sctag_pkg::CMD_FREE) && ent_valid && tag_eq) begin
         valid_in[dat_idx_ff] = 1'b0;
      end
      if (apply_fire) begin
         case (cmd_ff)
            sctag_pkg::CMD_STORE: begin
               if (pick_ok) begin
                  valid_in[pick_idx] = 1'b1;
                  dirty_in[pick_idx] = mdirty_ff;
               end
            end
            sctag_pkg::CMD_INVALIDATE: begin
               valid_in = '0;
            end
            sctag_pkg::CMD_FLUSH: begin
               if (pick_ok) begin
                  dirty_in[pick_idx] = 1'b0;
               end
            end
            default: begin
               valid_in = valid_ff;
            end
         endcase
      end
   end

   // flush ends once no valid dirty entry remains after this one
   assign flush_last = ~|(valid_in & dirty_in);

   // sequencer and scan bookkeeping
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      sector_in     = sector_ff;
      mdirty_in     = mdirty_ff;
      ts_in         = ts_ff;
      rd_idx_in     = rd_idx_ff;
      issue_on_in   = issue_on_ff;
      dat_vld_in    = (state_ff == ST_SCAN) && issue_on_ff;
      dat_idx_in    = rd_idx_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      cand_found_in = cand_found_ff;
      cand_idx_in   = cand_idx_ff;
      best_in       = best_ff;
      scan_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_if.cmd;
               sector_in = req_if.sector;
               mdirty_in = req_if.mark_dirty;
               ts_in     = req_if.timestamp;
               case (req_if.cmd) inside
                  sctag_pkg::CMD_LOOKUP, sctag_pkg::CMD_STORE,
                  sctag_pkg::CMD_FREE, sctag_pkg::CMD_FLUSH: begin
                     state_in   = ST_SCAN;
                     scan_start = 1'b1;
                  end
                  default: begin
                     state_in = ST_APPLY;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // advance the read address
            if (issue_on_ff) begin
               rd_idx_in = rd_idx_ff + 1'b1;
               if (rd_idx_ff == sctag_pkg::LAST_IDX) begin
                  issue_on_in = 1'b0;
               end
            end
            if (dat_vld_ff) begin
               if (ent_valid && tag_eq && !hit_found_ff) begin
                  hit_found_in = 1'b1;
                  hit_idx_in   = dat_idx_ff;
               end
               if (cmd_ff == sctag_pkg::CMD_STORE) begin
                  if (!ent_valid) begin
                     free_found_in = 1'b1;
                     free_idx_in   = dat_idx_ff;
                  end
                  if (!ent_dirty && (!cand_found_ff || lt)) begin
                     cand_found_in = 1'b1;
                     cand_idx_in   = dat_idx_ff;
                     best_in       = sctag_pkg::TAG_W'(age_rd_ff);
                  end
               end
               if ((cmd_ff == sctag_pkg::CMD_FLUSH) && ent_valid && ent_dirty &&
                   (!cand_found_ff || lt)) begin
                  cand_found_in = 1'b1;
                  cand_idx_in   = dat_idx_ff;
                  best_in       = tag_rd_ff;
               end
               if (dat_idx_ff == sctag_pkg::LAST_IDX) begin
                  state_in = ST_APPLY;
               end
            end
         end
         ST_APPLY: begin
            if (apply_fire) begin
               state_in = ST_IDLE;
               // another dirty entry waits: run the pass again
               if ((cmd_ff == sctag_pkg::CMD_FLUSH) && pick_ok && !flush_last) begin
                  state_in   = ST_SCAN;
                  scan_start = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (scan_start) begin
         rd_idx_in     = '0;
         issue_on_in   = 1'b1;
         dat_vld_in    = 1'b0;
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
         cand_found_in = 1'b0;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      success_in      = success_ff;
      slot_in         = slot_ff;
      flush_sector_in = flush_sector_ff;
      any_dirty_in    = any_dirty_ff;
      last_in         = last_ff;
      if (apply_fire) begin
         rsp_valid_in    = 1'b1;
         success_in      = 1'b0;
         slot_in         = '0;
         flush_sector_in = '0;
         any_dirty_in    = |(valid_in & dirty_in);
         last_in         = 1'b1;
         case (cmd_ff)
            sctag_pkg::CMD_LOOKUP: begin
               if (hit_found_ff) begin
                  success_in = 1'b1;
                  slot_in    = sctag_pkg::SLOT_W'(hit_idx_ff);
               end
            end
            sctag_pkg::CMD_STORE: begin
               if (pick_ok) begin
                  success_in = 1'b1;
                  slot_in    = sctag_pkg::SLOT_W'(pick_idx);
               end
            end
            sctag_pkg::CMD_FLUSH: begin
               // every dirty entry is written back by the end, so report clean
               any_dirty_in = 1'b0;
               if (pick_ok) begin
                  success_in      = 1'b1;
                  slot_in         = sctag_pkg::SLOT_W'(pick_idx);
                  flush_sector_in = best_ff;
                  last_in         = flush_last;
               end
            end
            default: begin
               success_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_on_ff   <= 1'b0;
         dat_vld_ff    <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         cand_found_ff <= 1'b0;
         valid_ff      <= '0;
         dirty_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_on_ff   <= issue_on_in;
         dat_vld_ff    <= dat_vld_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         cand_found_ff <= cand_found_in;
         valid_ff      <= valid_in;
         dirty_ff      <= dirty_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      sector_ff       <= sector_in;
      mdirty_ff       <= mdirty_in;
      ts_ff           <= ts_in;
      rd_idx_ff       <= rd_idx_in;
      dat_idx_ff      <= dat_idx_in;
      hit_idx_ff      <= hit_idx_in;
      free_idx_ff     <= free_idx_in;
      cand_idx_ff     <= cand_idx_in;
      best_ff         <= best_in;
      success_ff      <= success_in;
      slot_ff         <= slot_in;
      flush_sector_ff <= flush_sector_in;
      any_dirty_ff    <= any_dirty_in;
      last_ff         <= last_in;
   end

endmodule
